/* hdl/cfd_pkg.sv */
// cfd_pkg: shared types, register indexes and limits for the command frame deframer
// no dependencies; imported by every module under hdl
package cfd_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int WIN_DEPTH   = FRAME_BYTES - 1;
    localparam int FILL_W      = $clog2(FRAME_BYTES);

    // register indexes on the configuration port
    localparam logic [1:0] CFG_HEAD     = 2'd0;
    localparam logic [1:0] CFG_RESERVED = 2'd1;
    localparam logic [1:0] CFG_TAIL     = 2'd2;

    // float32 limits on the raw bit patterns
    localparam logic [31:0] PITCH_LIMIT = 32'h42B4_0000;
    localparam logic [31:0] YAW_LIMIT   = 32'h4334_0000;
    localparam logic [31:0] DIST_LIMIT  = 32'h42C8_0000;
    localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } cfd_in_t;

    typedef struct packed {
        logic        command_found;
        logic        fire_flag;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_bits;
        logic [31:0] distance_bits;
    } cfd_out_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] reserved_byte;
        logic [7:0] tail_byte;
    } cfd_cfg_t;

    // status from the frame checker to the pipeline control
    typedef struct packed {
        logic produces;
        logic hit;
    } cfd_stat_t;

endpackage

/* hdl/cfd_input_stage.sv */
// cfd_input_stage: input register for received byte beats
// depends on cfd_pkg
module cfd_input_stage
    import cfd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  cfd_in_t s_data,
    input  logic    advance,
    output logic    beat_valid,
    output cfd_in_t beat
);

    logic    valid_reg, valid_next;
    cfd_in_t data_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = data_reg;

endmodule

/* hdl/cfd_frame_check.sv */
// cfd_frame_check: sliding byte window, frame match and per-buffer found mark
// depends on cfd_pkg
module cfd_frame_check
    import cfd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfd_cfg_t  cfg,
    input  logic      beat_valid,
    input  cfd_in_t   beat,
    input  logic      advance,
    output cfd_stat_t stat,
    output cfd_out_t  result
);

    logic [7:0]        win_reg [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic              found_reg;

    logic [7:0]  frame [FRAME_BYTES];
    logic [31:0] pitch, yaw, distance;
    logic        match, hit, found_next, not_found;

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            frame[i] = win_reg[i];
        end
        frame[FRAME_BYTES-1] = beat.data_byte;
    end

    // little-endian float fields
    assign pitch    = {frame[5], frame[4], frame[3], frame[2]};
    assign yaw      = {frame[9], frame[8], frame[7], frame[6]};
    assign distance = {frame[13], frame[12], frame[11], frame[10]};

    assign match = (frame[0] == cfg.head_byte)
                && (frame[FRAME_BYTES-2] == cfg.reserved_byte)
                && (frame[FRAME_BYTES-1] == cfg.tail_byte)
                && (frame[1][7:1] == 7'd0)
                && ({1'b0, pitch[30:0]} <= PITCH_LIMIT)
                && ({1'b0, yaw[30:0]} <= YAW_LIMIT)
                && ((distance <= DIST_LIMIT) || (distance == NEG_ZERO));

    assign hit        = (fill_reg == FILL_W'(WIN_DEPTH)) && !found_reg && match;
    assign found_next = found_reg || hit;
    assign not_found  = beat.buffer_end && !found_next;

    assign stat.hit      = beat_valid && hit;
    assign stat.produces = beat_valid && (hit || not_found);

    always_comb begin
        result = '0;
        if (hit) begin
            result.command_found = 1'b1;
            result.fire_flag     = frame[1][0];
            result.pitch_bits    = pitch;
            result.yaw_bits      = yaw;
            result.distance_bits = distance;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_reg[i] <= 8'd0;
            end
            fill_reg  <= '0;
            found_reg <= 1'b0;
        end else if (advance) begin
            if (beat.buffer_end) begin
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    win_reg[i] <= 8'd0;
                end
                fill_reg  <= '0;
                found_reg <= 1'b0;
            end else begin
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WIN_DEPTH-1] <= beat.data_byte;
                if (fill_reg != FILL_W'(WIN_DEPTH)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                found_reg <= found_next;
            end
        end
    end

endmodule

/* hdl/cfd_output_reg.sv */
// cfd_output_reg: result register facing the m_ channel
// depends on cfd_pkg
module cfd_output_reg
    import cfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  cfd_out_t load_data,
    output logic     free,
    output logic     m_valid,
    input  logic     m_ready,
    output cfd_out_t m_data
);

    logic     valid_reg, valid_next;
    cfd_out_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* hdl/command_frame_deframer.sv */
// command_frame_deframer: top level, config registers and pipeline control
// depends on cfd_pkg, cfd_input_stage, cfd_frame_check, cfd_output_reg
//
// usage
// the s_ channel carries one received byte per beat with a buffer_end flag on
// the last byte of each receive buffer. the m_ channel carries results: a
// command (command_found 1) for the first valid 16-byte frame seen in a
// buffer, or a not-found beat (all fields 0) when a buffer ends without one.
// head, reserved and tail bytes are set through cfg_wdata/cfg_index/cfg_we,
// written only while the block is idle: a rule for the user that the block
// does not enforce; index 3 is ignored.
// throughput: one byte per cycle while no result is held on a stalled m_
// side, set by the single combinational check between the input register
// and the result register; bytes with no result never wait on the m_ side.
// stall: when m_ready is low and a result is held, a byte that would give a
// new result waits in the input register and s_ready drops.
// reset (aresetn low, synchronous): window, fill count, found mark, config
// registers and both valid flags clear; no clearing pass is needed.
module command_frame_deframer
    import cfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  cfd_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output cfd_out_t   m_data
);

    cfd_cfg_t  cfg_reg;
    logic      beat_valid;
    cfd_in_t   beat;
    cfd_stat_t stat;
    cfd_out_t  result;
    logic      out_free, advance, load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HEAD:     cfg_reg.head_byte     <= cfg_wdata;
                CFG_RESERVED: cfg_reg.reserved_byte <= cfg_wdata;
                CFG_TAIL:     cfg_reg.tail_byte     <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // a beat moves on unless it has a result and the output is still held
    assign advance = beat_valid && (!stat.produces || out_free);
    assign load    = advance && stat.produces;

    cfd_input_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    cfd_frame_check u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .beat_valid (beat_valid),
        .beat       (beat),
        .advance    (advance),
        .stat       (stat),
        .result     (result)
    );

    cfd_output_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .load_data (result),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    // not-found beats carry an all-zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.command_found) |->
            (!m_data.fire_flag && m_data.pitch_bits == 32'd0
             && m_data.yaw_bits == 32'd0 && m_data.distance_bits == 32'd0))
        else $error("not-found result with nonzero payload");

    // an emitted command always passes the pitch and yaw range checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.command_found) |->
            ({1'b0, m_data.pitch_bits[30:0]} <= PITCH_LIMIT
             && {1'b0, m_data.yaw_bits[30:0]} <= YAW_LIMIT))
        else $error("command result out of range");

    // input only backs up behind a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without output stall");

    // a hit is loaded into the output in the cycle it advances
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stat.hit) |=> (m_valid && m_data.command_found))
        else $error("command lost on the way to the output");
`endif

endmodule

/* dv/command_frame_deframer_tb.sv */
// command_frame_deframer_tb: self-checking bench for the command frame deframer
// depends on cfd_pkg and hdl/command_frame_deframer.sv; directed rows, then random
// receive buffers checked beat by beat against an in-bench decoder of the byte window
module command_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfd_pkg::*;

    localparam int FRAME_LEN    = 16;
    localparam int HIST_LEN     = FRAME_LEN - 1;
    localparam int RANDOM_BYTES = 400;
    localparam int MIN_RESULTS  = 48;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_LIMIT  = 40;

    // float32 bit patterns the decoder works with
    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] MAG_BITS  = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_PITCH = 32'h42B4_0000;   // 90.0
    localparam logic [31:0] MAX_YAW   = 32'h4334_0000;   // 180.0
    localparam logic [31:0] MAX_DIST  = 32'h42C8_0000;   // 100.0
    localparam logic [31:0] POS_INF   = 32'h7F80_0000;
    localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;

    // index past the last register, written to show it is ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam cfd_out_t NOT_FOUND = '0;
    // pitch +90, yaw -180, distance -0.0, fire set
    localparam cfd_out_t LIMIT_CMD = {1'b1, 1'b1, 32'h42B4_0000, 32'hC334_0000, 32'h8000_0000};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
        logic       typed;        // expectation is given in the row itself
        logic       has_result;
        cfd_out_t   result;
    } stim_row_t;

    // columns: byte, buffer end, typed, result expected, result
    stim_row_t directed_rows [0:18] = '{
        {8'hFF, 1'b1, 1'b1, 1'b1, NOT_FOUND},   // one-byte buffer
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // head
        {8'h01, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // fire
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // pitch, exactly at the limit
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'hB4, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'h42, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // yaw, negative limit
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'h34, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'hC3, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // distance -0.0
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'h80, 1'b0, 1'b0, 1'b0, NOT_FOUND},
        {8'h00, 1'b0, 1'b0, 1'b0, NOT_FOUND},   // reserved
        {8'h00, 1'b0, 1'b1, 1'b1, LIMIT_CMD},   // tail completes the command
        {8'h00, 1'b1, 1'b1, 1'b0, NOT_FOUND},   // buffer end after a command: silent
        {8'h00, 1'b1, 1'b1, 1'b1, NOT_FOUND}    // one-byte buffer again
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_HEAD;
    logic [7:0] cfg_wdata = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    cfd_in_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    cfd_out_t   m_data;

    // decoder state and register copies
    logic [7:0] want_head, want_resv, want_tail;
    logic [7:0] hist_q [0:HIST_LEN-1];
    int         hist_fill;
    bit         cmd_seen;

    cfd_out_t   pending_results [$];
    logic [7:0] buffer_bytes [$];

    int errors         = 0;
    int bytes_sent     = 0;
    int buffers_sent   = 0;
    int results_seen   = 0;
    int commands_seen  = 0;
    int settings_used  = 1;

    always #5 aclk = ~aclk;

    command_frame_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    function automatic void clear_window();
        for (int i = 0; i < HIST_LEN; i++) hist_q[i] = '0;
        hist_fill = 0;
        cmd_seen  = 1'b0;
    endfunction

    // advance the window by one byte; returns 1 when the byte gives a result
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output cfd_out_t res);
        logic [7:0]  fr [0:FRAME_LEN-1];
        logic [31:0] pitch, yaw, distance;
        bit          hit, emit;
        for (int i = 0; i < HIST_LEN; i++) fr[i] = hist_q[i];
        fr[FRAME_LEN-1] = b;
        pitch    = {fr[5], fr[4], fr[3], fr[2]};
        yaw      = {fr[9], fr[8], fr[7], fr[6]};
        distance = {fr[13], fr[12], fr[11], fr[10]};
        hit = hist_fill == HIST_LEN && !cmd_seen &&
              fr[0] == want_head && fr[FRAME_LEN-2] == want_resv &&
              fr[FRAME_LEN-1] == want_tail && fr[1] <= 8'd1 &&
              (pitch & MAG_BITS) <= MAX_PITCH && (yaw & MAG_BITS) <= MAX_YAW &&
              (distance <= MAX_DIST || distance == SIGN_BIT);
        res  = NOT_FOUND;
        emit = hit;
        if (hit) begin
            cmd_seen = 1'b1;
            res = {1'b1, fr[1][0], pitch, yaw, distance};
        end
        for (int i = 0; i < HIST_LEN - 1; i++) hist_q[i] = hist_q[i+1];
        hist_q[HIST_LEN-1] = b;
        if (hist_fill < HIST_LEN) hist_fill++;
        if (last) begin
            if (!cmd_seen) emit = 1'b1;   // not-found beat, res is still all zero
            clear_window();
        end
        return emit;
    endfunction

    function automatic logic [31:0] pick_angle(input logic [31:0] lim);
        logic [31:0] sign;
        sign = $urandom_range(0, 1) ? SIGN_BIT : 32'h0;
        case ($urandom_range(0, 19))
            0:       return sign;
            1:       return sign | lim;
            2:       return sign | (lim + 32'd1);
            3:       return sign | POS_INF;
            4:       return sign | QUIET_NAN | $urandom_range(0, 32'h003F_FFFF);
            5:       return $urandom;
            default: return sign | $urandom_range(0, lim);
        endcase
    endfunction

    function automatic logic [31:0] pick_distance();
        case ($urandom_range(0, 19))
            0:       return 32'h0;
            1:       return MAX_DIST;
            2:       return SIGN_BIT;
            3:       return MAX_DIST + 32'd1;
            4:       return SIGN_BIT | $urandom_range(1, MAX_DIST);
            5:       return $urandom_range(0, 1) ? POS_INF : QUIET_NAN;
            6:       return $urandom;
            default: return $urandom_range(0, MAX_DIST);
        endcase
    endfunction

    // well-formed frame with random fields; damage breaks one of the framing bytes
    function automatic void push_frame(input bit damage);
        logic [7:0]  fr [0:FRAME_LEN-1];
        logic [31:0] p, y, d;
        logic [7:0]  flip;
        p = pick_angle(MAX_PITCH);
        y = pick_angle(MAX_YAW);
        d = pick_distance();
        flip = 8'($urandom_range(1, 255));
        fr[0] = want_head;
        fr[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, 255))
                                             : 8'($urandom_range(0, 1));
        for (int i = 0; i < 4; i++) begin
            fr[2+i]  = p[8*i +: 8];
            fr[6+i]  = y[8*i +: 8];
            fr[10+i] = d[8*i +: 8];
        end
        fr[FRAME_LEN-2] = want_resv;
        fr[FRAME_LEN-1] = want_tail;
        if (damage) begin
            case ($urandom_range(0, 2))
                0:       fr[0] = fr[0] ^ flip;
                1:       fr[FRAME_LEN-2] = fr[FRAME_LEN-2] ^ flip;
                default: fr[FRAME_LEN-1] = fr[FRAME_LEN-1] ^ flip;
            endcase
        end
        for (int i = 0; i < FRAME_LEN; i++) buffer_bytes.push_back(fr[i]);
    endfunction

    function automatic void push_noise(input int n);
        repeat (n) buffer_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_buffer();
        int kind;
        buffer_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            push_noise($urandom_range(1, FRAME_LEN - 1));
        end else if (kind < 3) begin
            push_noise($urandom_range(FRAME_LEN, 40));
        end else begin
            push_noise($urandom_range(0, 5));
            push_frame($urandom_range(0, 4) == 0);
            // a second frame in the buffer is ignored if the first gave a command
            if ($urandom_range(0, 2) == 0) begin
                push_noise($urandom_range(0, 3));
                push_frame(1'b0);
            end
            // no trailing bytes puts the command on the buffer's last byte
            push_noise($urandom_range(0, 4));
        end
    endfunction

    // offer one byte after gap idle cycles, return once it is accepted
    task automatic send_byte(input logic [7:0] b, input logic last, input int gap,
                             output bit emit, output cfd_out_t res);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cfd_in_t'({b, last});
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        emit = decode_byte(b, last, res);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] h, input logic [7:0] r,
                              input logic [7:0] t, input logic [7:0] spare);
        logic [1:0] idx [0:3];
        logic [7:0] val [0:3];
        idx = '{CFG_HEAD, CFG_RESERVED, CFG_TAIL, CFG_SPARE};
        val = '{h, r, t, spare};
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_wdata <= val[k];
            @(posedge aclk);
            case (idx[k])
                CFG_HEAD:     want_head = val[k];
                CFG_RESERVED: want_resv = val[k];
                CFG_TAIL:     want_tail = val[k];
                default:      ;
            endcase
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic void match_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_result(input cfd_out_t got);
        cfd_out_t want;
        results_seen++;
        if (got.command_found === 1'b1) commands_seen++;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: result beat with none expected, expected nothing got %h",
                         $time, got);
            return;
        end
        want = pending_results.pop_front();
        match_field("command_found", 32'(want.command_found), 32'(got.command_found));
        match_field("fire_flag", 32'(want.fire_flag), 32'(got.fire_flag));
        match_field("pitch_bits", want.pitch_bits, got.pitch_bits);
        match_field("yaw_bits", want.yaw_bits, got.yaw_bits);
        match_field("distance_bits", want.distance_bits, got.distance_bits);
    endfunction

    // result side: random ready gaps, calm stretches, and long hold-offs
    initial begin
        int gap;
        int calm_left;
        bit calm;
        calm_left = 0;
        calm = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm_left == 0) begin
                calm = $urandom_range(0, 2) == 0;
                calm_left = 16;
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, 8);
            // hold off long enough for the block to back up into s_ready
            if (results_seen % 30 == 10) gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_result(m_data);
        end
    end

    initial begin
        bit       emit;
        bit       burst;
        cfd_out_t res;
        int       phase_bytes;
        int       phase_results;
        want_head = '0;
        want_resv = '0;
        want_tail = '0;
        clear_window();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data_byte, directed_rows[i].buffer_end,
                      $urandom_range(0, 8), emit, res);
            if (directed_rows[i].typed) begin
                if (directed_rows[i].has_result)
                    pending_results.push_back(directed_rows[i].result);
            end else if (emit) begin
                pending_results.push_back(res);
            end
        end
        buffers_sent += 3;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_config(8'hFF, 8'hFF, 8'hFF, 8'($urandom));
                2:       set_config(8'h00, 8'h00, 8'h00, 8'hFF);
                default: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'h00);
            endcase
            phase_bytes = 0;
            phase_results = 0;
            while (phase_bytes < RANDOM_BYTES / PHASES ||
                   phase_results < MIN_RESULTS / PHASES) begin
                build_buffer();
                burst = $urandom_range(0, 2) == 0;
                foreach (buffer_bytes[i]) begin
                    send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1,
                              burst ? 0 : $urandom_range(0, 8), emit, res);
                    if (emit) begin
                        pending_results.push_back(res);
                        phase_results++;
                    end
                end
                phase_bytes += buffer_bytes.size();
                buffers_sent++;
            end
            wait_drained();
        end

        $display("%0d bytes in %0d buffers over %0d register settings", bytes_sent,
                 buffers_sent, settings_used);
        $display("%0d result beats checked, %0d of them commands", results_seen,
                 commands_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still expected", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
